// ----- rtl/mfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mfr_pkg;

   localparam int SEEN_DEPTH  = 64;
   localparam int ROUTE_DEPTH = 16;
   localparam int SEEN_IW     = $clog2(SEEN_DEPTH);
   localparam int ROUTE_IW    = $clog2(ROUTE_DEPTH);
   localparam int SCAN_W      = (SEEN_IW > ROUTE_IW) ? SEEN_IW : ROUTE_IW;
   localparam int RCNT_W      = $clog2(ROUTE_DEPTH + 1);
   localparam int MAX_RES     = 3;
   localparam int CSR_AW      = 5;

   localparam logic [31:0] BROADCAST_ID = 32'hFFFF_FFFF;
   localparam logic [31:0] MS_PER_S     = 32'd1000;
   localparam logic [7:0]  OWN_TTL      = 8'd60;
   localparam logic [7:0]  ACK_TTL      = 8'd30;

   localparam logic [1:0] ACT_RX     = 2'd0;
   localparam logic [1:0] ACT_SEND   = 2'd1;
   localparam logic [1:0] ACT_TICK   = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam logic [2:0] KIND_NONE      = 3'd0;
   localparam logic [2:0] KIND_DELIVER   = 3'd1;
   localparam logic [2:0] KIND_ACK       = 3'd2;
   localparam logic [2:0] KIND_RELAY     = 3'd3;
   localparam logic [2:0] KIND_HEARTBEAT = 3'd4;
   localparam logic [2:0] KIND_LOCAL     = 3'd5;

   localparam logic [3:0] MSG_HEARTBEAT = 4'd0;
   localparam logic [3:0] MSG_INCIDENT  = 4'd1;
   localparam logic [3:0] MSG_ACK       = 4'd2;
   localparam logic [3:0] MSG_NACK      = 4'd3;

   localparam logic [1:0] PRI_LOW  = 2'd0;
   localparam logic [1:0] PRI_HIGH = 2'd2;

   localparam logic [2:0] REG_DEVICE_ID = 3'd0;
   localparam logic [2:0] REG_MAX_HOPS  = 3'd1;
   localparam logic [2:0] REG_HB_INT    = 3'd2;
   localparam logic [2:0] REG_CLEAN_INT = 3'd3;
   localparam logic [2:0] REG_MAX_AGE   = 3'd4;

   localparam logic [31:0] RST_DEVICE_ID = 32'd0;
   localparam logic [7:0]  RST_MAX_HOPS  = 8'd5;
   localparam logic [31:0] RST_HB_INT    = 32'd30000;
   localparam logic [31:0] RST_CLEAN_INT = 32'd60000;
   localparam logic [31:0] RST_MAX_AGE   = 32'd300000;

   typedef struct packed {
      logic [31:0] device_id;
      logic [7:0]  max_hops;
      logic [31:0] hb_int;
      logic [31:0] clean_int;
      logic [31:0] max_age;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] now;
      logic [31:0] src;
      logic [31:0] dst;
      logic [31:0] seq;
      logic [3:0]  mtype;
      logic [1:0]  pri;
      logic [7:0]  hops;
      logic [7:0]  ttl;
      logic [31:0] sent;
      logic        for_us;
      logic        unicast;
      logic        relay_ok;
   } item_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] src;
      logic [31:0] dst;
      logic [31:0] seq;
      logic [3:0]  mtype;
      logic [1:0]  pri;
      logic [7:0]  hops;
      logic [7:0]  ttl;
      logic [31:0] tstamp;
      logic [31:0] acked;
   } res_type;

   typedef struct packed {
      logic                      valid;
      logic [1:0]                n;
      res_type [MAX_RES-1:0]     list;
      logic [4:0]                count;
   } hand_type;

endpackage
`default_nettype wire

// ----- rtl/mfr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mfr_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mfr_pkg::cfg_type  cfg,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_action,
   input  wire logic [31:0]       req_now_ms,
   input  wire logic [31:0]       req_source_id,
   input  wire logic [31:0]       req_destination_id,
   input  wire logic [31:0]       req_seq_num,
   input  wire logic [3:0]        req_msg_type,
   input  wire logic [1:0]        req_priority_req,
   input  wire logic [7:0]        req_hop_count,
   input  wire logic [7:0]        req_ttl_s,
   input  wire logic [31:0]       req_sent_time_ms,
   output logic                   q_valid,
   output mfr_pkg::item_type      q_item,
   input  wire logic              q_pop
);

   localparam int QDEPTH = 2;
   localparam int QAW    = $clog2(QDEPTH);

   mfr_pkg::item_type             fifo_ff [QDEPTH];
   logic [QAW-1:0]                wp_ff, wp_in, rp_ff, rp_in;
   logic [QAW:0]                  cnt_ff, cnt_in;
   mfr_pkg::item_type             cls;
   logic [31:0]                   age, lim;
   logic                          push;

   always_comb begin
      age = req_now_ms - req_sent_time_ms;
      // whole seconds of age <= ttl  <=>  age < (ttl + 1) seconds
      lim = 32'(req_ttl_s) * mfr_pkg::MS_PER_S + (mfr_pkg::MS_PER_S - 32'd1);
      cls.action   = req_action;
      cls.now      = req_now_ms;
      cls.src      = req_source_id;
      cls.dst      = req_destination_id;
      cls.seq      = req_seq_num;
      cls.mtype    = req_msg_type;
      cls.pri      = req_priority_req;
      cls.hops     = req_hop_count;
      cls.ttl      = req_ttl_s;
      cls.sent     = req_sent_time_ms;
      cls.for_us   = (req_destination_id == cfg.device_id) ||
                     (req_destination_id == mfr_pkg::BROADCAST_ID);
      cls.unicast  = req_destination_id != mfr_pkg::BROADCAST_ID;
      cls.relay_ok = cls.for_us && (req_hop_count < cfg.max_hops) && (age <= lim) &&
                     (req_msg_type != mfr_pkg::MSG_ACK) &&
                     (req_msg_type != mfr_pkg::MSG_NACK);
   end

   assign req_ready = cnt_ff != (QAW+1)'(QDEPTH);
   assign q_valid   = cnt_ff != '0;
   assign q_item    = fifo_ff[rp_ff];
   assign push      = req_valid && req_ready;

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == QAW'(QDEPTH - 1)) ? '0 : wp_ff + QAW'(1);
      end
      if (q_pop) begin
         rp_in = (rp_ff == QAW'(QDEPTH - 1)) ? '0 : rp_ff + QAW'(1);
      end
      if (push && !q_pop) begin
         cnt_in = cnt_ff + (QAW+1)'(1);
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - (QAW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wp_ff] <= cls;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/mfr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mfr_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mfr_pkg::cfg_type  cfg,
   input  wire logic              q_valid,
   input  wire mfr_pkg::item_type q_item,
   output logic                   q_pop,
   input  wire logic              emit_free,
   output mfr_pkg::hand_type      hand
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_START  = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DECIDE = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   typedef enum logic [7:0] {
      PH_DUP     = 8'b0000_0001,
      PH_ROUTE   = 8'b0000_0010,
      PH_ACK     = 8'b0000_0100,
      PH_RELAY   = 8'b0000_1000,
      PH_LOCAL   = 8'b0001_0000,
      PH_HB      = 8'b0010_0000,
      PH_SWEEP_R = 8'b0100_0000,
      PH_SWEEP_S = 8'b1000_0000
   } phase_type;

   localparam int SW  = mfr_pkg::SCAN_W;
   localparam int SIW = mfr_pkg::SEEN_IW;
   localparam int RIW = mfr_pkg::ROUTE_IW;

   state_type                          st_ff, st_in;
   phase_type                          ph_ff, ph_in;
   mfr_pkg::item_type                  cur_ff, cur_in;
   logic                               tbl_ff, tbl_in;
   logic [31:0]                        tgt_ff, tgt_in;
   logic                               run_ff, run_in;
   logic [SW-1:0]                      addr_ff, addr_in;
   logic                               dv_ff, dv_in;
   logic [SW-1:0]                      di_ff, di_in;
   logic                               fnd_ff, fnd_in;
   logic [SW-1:0]                      fidx_ff, fidx_in;
   logic                               fre_ff, fre_in;
   logic [SW-1:0]                      ridx_ff, ridx_in;
   logic [31:0]                        best_ff, best_in;
   logic [SW-1:0]                      oidx_ff, oidx_in;
   logic [mfr_pkg::SEEN_DEPTH-1:0]     seen_valid_ff, seen_valid_in;
   logic [mfr_pkg::ROUTE_DEPTH-1:0]    route_valid_ff, route_valid_in;
   logic [mfr_pkg::RCNT_W-1:0]         rcnt_ff, rcnt_in;
   logic [31:0]                        next_seq_ff, next_seq_in;
   logic [31:0]                        last_hb_ff, last_hb_in;
   logic [31:0]                        last_sw_ff, last_sw_in;
   mfr_pkg::res_type [mfr_pkg::MAX_RES-1:0] res_ff, res_in;
   logic [1:0]                         n_ff, n_in;

   logic [31:0]                        seen_key_mem   [mfr_pkg::SEEN_DEPTH];
   logic [31:0]                        seen_stamp_mem [mfr_pkg::SEEN_DEPTH];
   logic [31:0]                        route_node_mem [mfr_pkg::ROUTE_DEPTH];
   logic [31:0]                        route_stamp_mem[mfr_pkg::ROUTE_DEPTH];
   logic [31:0]                        rd_key_ff, rd_kstamp_ff, rd_node_ff, rd_rstamp_ff;

   logic                               sk_we, rt_we;
   logic [SW-1:0]                      slot;
   logic [31:0]                        wkey;
   logic [31:0]                        cnt32;

   always_comb begin
      logic                            v;
      logic [31:0]                     key, stamp, age;
      logic [SW-1:0]                   last_idx;
      logic                            start, s_tbl, relay_chk, sweep_chk, finish, add;
      logic [31:0]                     s_tgt;
      phase_type                       s_ph;
      mfr_pkg::res_type                r;

      st_in          = st_ff;
      ph_in          = ph_ff;
      cur_in         = cur_ff;
      tbl_in         = tbl_ff;
      tgt_in         = tgt_ff;
      run_in         = run_ff;
      addr_in        = addr_ff;
      dv_in          = dv_ff;
      di_in          = di_ff;
      fnd_in         = fnd_ff;
      fidx_in        = fidx_ff;
      fre_in         = fre_ff;
      ridx_in        = ridx_ff;
      best_in        = best_ff;
      oidx_in        = oidx_ff;
      seen_valid_in  = seen_valid_ff;
      route_valid_in = route_valid_ff;
      rcnt_in        = rcnt_ff;
      next_seq_in    = next_seq_ff;
      last_hb_in     = last_hb_ff;
      last_sw_in     = last_sw_ff;
      res_in         = res_ff;
      n_in           = n_ff;
      q_pop          = 1'b0;
      sk_we          = 1'b0;
      rt_we          = 1'b0;
      wkey           = cur_ff.seq;
      v              = 1'b0;
      key            = '0;
      stamp          = '0;
      age            = '0;
      start          = 1'b0;
      s_tbl          = 1'b0;
      s_tgt          = '0;
      s_ph           = PH_DUP;
      relay_chk      = 1'b0;
      sweep_chk      = 1'b0;
      finish         = 1'b0;
      add            = 1'b0;
      r              = '0;
      last_idx       = tbl_ff ? SW'(mfr_pkg::ROUTE_DEPTH - 1) : SW'(mfr_pkg::SEEN_DEPTH - 1);
      slot           = fnd_ff ? fidx_ff : (fre_ff ? ridx_ff : oidx_ff);

      // frame header this node originates
      r.src    = cfg.device_id;
      r.dst    = mfr_pkg::BROADCAST_ID;
      r.seq    = next_seq_ff;
      r.ttl    = mfr_pkg::OWN_TTL;
      r.tstamp = cur_ff.now;

      case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_item;
               st_in  = ST_START;
            end
         end
         ST_START: begin
            res_in = '0;
            n_in   = '0;
            case (cur_ff.action)
               mfr_pkg::ACT_RX: begin
                  start = 1'b1;
                  s_tgt = cur_ff.seq;
                  s_ph  = PH_DUP;
               end
               mfr_pkg::ACT_SEND: begin
                  start = 1'b1;
                  s_tgt = next_seq_ff;
                  s_ph  = PH_LOCAL;
               end
               mfr_pkg::ACT_TICK: begin
                  if (cur_ff.now - last_hb_ff > cfg.hb_int) begin
                     start = 1'b1;
                     s_tgt = next_seq_ff;
                     s_ph  = PH_HB;
                  end else begin
                     sweep_chk = 1'b1;
                  end
               end
               default: finish = 1'b1;
            endcase
         end
         ST_SCAN: begin
            if (run_ff) begin
               addr_in = addr_ff + SW'(1);
               if (addr_ff == last_idx) begin
                  run_in = 1'b0;
               end
            end
            dv_in = run_ff;
            di_in = addr_ff;
            if (dv_ff) begin
               v     = tbl_ff ? route_valid_ff[di_ff[RIW-1:0]] : seen_valid_ff[di_ff[SIW-1:0]];
               key   = tbl_ff ? rd_node_ff : rd_key_ff;
               stamp = tbl_ff ? rd_rstamp_ff : rd_kstamp_ff;
               age   = cur_ff.now - stamp;
               if (v && key == tgt_ff && !fnd_ff) begin
                  fnd_in  = 1'b1;
                  fidx_in = di_ff;
               end
               if (!v && !fre_ff) begin
                  fre_in  = 1'b1;
                  ridx_in = di_ff;
               end
               if (di_ff == '0 || age > best_ff) begin
                  best_in = age;
                  oidx_in = di_ff;
               end
               if ((ph_ff == PH_SWEEP_R || ph_ff == PH_SWEEP_S) && v && age > cfg.max_age) begin
                  if (tbl_ff) begin
                     route_valid_in[di_ff[RIW-1:0]] = 1'b0;
                     rcnt_in = rcnt_ff - mfr_pkg::RCNT_W'(1);
                  end else begin
                     seen_valid_in[di_ff[SIW-1:0]] = 1'b0;
                  end
               end
               if (di_ff == last_idx) begin
                  st_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            case (ph_ff)
               PH_DUP: begin
                  if (fnd_ff) begin
                     finish = 1'b1;
                  end else begin
                     sk_we = 1'b1;
                     seen_valid_in[slot[SIW-1:0]] = 1'b1;
                     start = 1'b1;
                     s_tbl = 1'b1;
                     s_tgt = cur_ff.src;
                     s_ph  = PH_ROUTE;
                  end
               end
               PH_ROUTE: begin
                  rt_we = 1'b1;
                  route_valid_in[slot[RIW-1:0]] = 1'b1;
                  if (!fnd_ff && fre_ff) begin
                     rcnt_in = rcnt_ff + mfr_pkg::RCNT_W'(1);
                  end
                  if (cur_ff.for_us) begin
                     add      = 1'b1;
                     r.kind   = mfr_pkg::KIND_DELIVER;
                     r.src    = cur_ff.src;
                     r.dst    = cur_ff.dst;
                     r.seq    = cur_ff.seq;
                     r.mtype  = cur_ff.mtype;
                     r.pri    = cur_ff.pri;
                     r.hops   = cur_ff.hops;
                     r.ttl    = cur_ff.ttl;
                     r.tstamp = cur_ff.sent;
                  end
                  if (cur_ff.for_us && cur_ff.unicast) begin
                     start = 1'b1;
                     s_tgt = next_seq_ff;
                     s_ph  = PH_ACK;
                  end else begin
                     relay_chk = 1'b1;
                  end
               end
               PH_ACK: begin
                  sk_we = 1'b1;
                  wkey  = next_seq_ff;
                  seen_valid_in[slot[SIW-1:0]] = 1'b1;
                  add     = 1'b1;
                  r.kind  = mfr_pkg::KIND_ACK;
                  r.dst   = cur_ff.src;
                  r.mtype = mfr_pkg::MSG_ACK;
                  r.pri   = mfr_pkg::PRI_HIGH;
                  r.ttl   = mfr_pkg::ACK_TTL;
                  r.acked = cur_ff.seq;
                  next_seq_in = next_seq_ff + 32'd1;
                  relay_chk   = 1'b1;
               end
               PH_RELAY: begin
                  sk_we = 1'b1;
                  seen_valid_in[slot[SIW-1:0]] = 1'b1;
                  add      = 1'b1;
                  r.kind   = mfr_pkg::KIND_RELAY;
                  r.src    = cur_ff.src;
                  r.dst    = cur_ff.dst;
                  r.seq    = cur_ff.seq;
                  r.mtype  = cur_ff.mtype;
                  r.pri    = cur_ff.pri;
                  r.hops   = cur_ff.hops + 8'd1;
                  r.ttl    = cur_ff.ttl;
                  r.tstamp = cur_ff.sent;
                  finish   = 1'b1;
               end
               PH_LOCAL: begin
                  sk_we = 1'b1;
                  wkey  = next_seq_ff;
                  seen_valid_in[slot[SIW-1:0]] = 1'b1;
                  add     = 1'b1;
                  r.kind  = mfr_pkg::KIND_LOCAL;
                  r.mtype = mfr_pkg::MSG_INCIDENT;
                  r.pri   = cur_ff.pri;
                  next_seq_in = next_seq_ff + 32'd1;
                  finish  = 1'b1;
               end
               PH_HB: begin
                  sk_we = 1'b1;
                  wkey  = next_seq_ff;
                  seen_valid_in[slot[SIW-1:0]] = 1'b1;
                  add     = 1'b1;
                  r.kind  = mfr_pkg::KIND_HEARTBEAT;
                  r.mtype = mfr_pkg::MSG_HEARTBEAT;
                  r.pri   = mfr_pkg::PRI_LOW;
                  next_seq_in = next_seq_ff + 32'd1;
                  last_hb_in  = cur_ff.now;
                  sweep_chk   = 1'b1;
               end
               PH_SWEEP_R: begin
                  start = 1'b1;
                  s_ph  = PH_SWEEP_S;
               end
               default: finish = 1'b1;
            endcase
         end
         ST_DONE: begin
            if (emit_free) begin
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase

      if (add) begin
         res_in[n_ff] = r;
         n_in         = n_ff + 2'd1;
      end
      if (relay_chk) begin
         if (cur_ff.relay_ok) begin
            start = 1'b1;
            s_tgt = cur_ff.seq;
            s_ph  = PH_RELAY;
         end else begin
            finish = 1'b1;
         end
      end
      if (sweep_chk) begin
         if (cur_ff.now - last_sw_ff > cfg.clean_int) begin
            last_sw_in = cur_ff.now;
            start      = 1'b1;
            s_tbl      = 1'b1;
            s_ph       = PH_SWEEP_R;
         end else begin
            finish = 1'b1;
         end
      end
      if (start) begin
         st_in   = ST_SCAN;
         ph_in   = s_ph;
         tbl_in  = s_tbl;
         tgt_in  = s_tgt;
         run_in  = 1'b1;
         addr_in = '0;
         dv_in   = 1'b0;
         fnd_in  = 1'b0;
         fre_in  = 1'b0;
      end
      if (finish) begin
         st_in = ST_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff          <= ST_IDLE;
         ph_ff          <= PH_DUP;
         run_ff         <= 1'b0;
         dv_ff          <= 1'b0;
         seen_valid_ff  <= '0;
         route_valid_ff <= '0;
         rcnt_ff        <= '0;
         next_seq_ff    <= 32'd1;
         last_hb_ff     <= '0;
         last_sw_ff     <= '0;
         n_ff           <= '0;
      end else begin
         st_ff          <= st_in;
         ph_ff          <= ph_in;
         run_ff         <= run_in;
         dv_ff          <= dv_in;
         seen_valid_ff  <= seen_valid_in;
         route_valid_ff <= route_valid_in;
         rcnt_ff        <= rcnt_in;
         next_seq_ff    <= next_seq_in;
         last_hb_ff     <= last_hb_in;
         last_sw_ff     <= last_sw_in;
         n_ff           <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      tbl_ff  <= tbl_in;
      tgt_ff  <= tgt_in;
      addr_ff <= addr_in;
      di_ff   <= di_in;
      fnd_ff  <= fnd_in;
      fidx_ff <= fidx_in;
      fre_ff  <= fre_in;
      ridx_ff <= ridx_in;
      best_ff <= best_in;
      oidx_ff <= oidx_in;
      res_ff  <= res_in;
   end

   always_ff @(posedge clock) begin
      if (sk_we) begin
         seen_key_mem[slot[SIW-1:0]]   <= wkey;
         seen_stamp_mem[slot[SIW-1:0]] <= cur_ff.now;
      end
      rd_key_ff    <= seen_key_mem[addr_ff[SIW-1:0]];
      rd_kstamp_ff <= seen_stamp_mem[addr_ff[SIW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (rt_we) begin
         route_node_mem[slot[RIW-1:0]]  <= cur_ff.src;
         route_stamp_mem[slot[RIW-1:0]] <= cur_ff.now;
      end
      rd_node_ff   <= route_node_mem[addr_ff[RIW-1:0]];
      rd_rstamp_ff <= route_stamp_mem[addr_ff[RIW-1:0]];
   end

   assign cnt32      = 32'(rcnt_ff);
   assign hand.valid = st_ff == ST_DONE;
   assign hand.n     = (n_ff == 2'd0) ? 2'd1 : n_ff;
   assign hand.list  = res_ff;
   assign hand.count = (cnt32 > 32'd31) ? 5'd31 : cnt32[4:0];

endmodule
`default_nettype wire

// ----- rtl/mfr_emit.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mfr_emit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mfr_pkg::hand_type hand,
   output logic                   emit_free,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [2:0]             rsp_kind,
   output logic [31:0]            rsp_out_source,
   output logic [31:0]            rsp_out_destination,
   output logic [31:0]            rsp_out_seq,
   output logic [3:0]             rsp_out_type,
   output logic [1:0]             rsp_out_priority,
   output logic [7:0]             rsp_out_hops,
   output logic [7:0]             rsp_out_ttl,
   output logic [31:0]            rsp_out_time,
   output logic [31:0]            rsp_acked_seq,
   output logic [4:0]             rsp_route_count,
   output logic                   rsp_last
);

   logic                                    busy_ff, busy_in;
   logic [1:0]                              idx_ff, idx_in;
   logic [1:0]                              n_ff;
   logic [4:0]                              cnt_ff;
   mfr_pkg::res_type [mfr_pkg::MAX_RES-1:0] list_ff;
   mfr_pkg::res_type                        cur;
   logic                                    load;

   assign emit_free = !busy_ff;
   assign load      = hand.valid && !busy_ff;
   assign cur       = list_ff[idx_ff];
   assign rsp_last  = idx_ff == (n_ff - 2'd1);

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (rsp_valid && rsp_ready) begin
         if (rsp_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         list_ff <= hand.list;
         n_ff    <= hand.n;
         cnt_ff  <= hand.count;
      end
   end

   assign rsp_valid           = busy_ff;
   assign rsp_kind            = cur.kind;
   assign rsp_out_source      = cur.src;
   assign rsp_out_destination = cur.dst;
   assign rsp_out_seq         = cur.seq;
   assign rsp_out_type        = cur.mtype;
   assign rsp_out_priority    = cur.pri;
   assign rsp_out_hops        = cur.hops;
   assign rsp_out_ttl         = cur.ttl;
   assign rsp_out_time        = cur.tstamp;
   assign rsp_acked_seq       = cur.acked;
   assign rsp_route_count     = cnt_ff;

endmodule
`default_nettype wire

// ----- rtl/mesh_flood_relay_dedup.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Mesh node header engine. Items enter a two-deep queue where they are
// classified, then a sequencer checks the seen table, refreshes the route
// table and builds up to three result frames, which an output buffer hands
// out with route_count and last. Both tables are searched one entry per cycle
// through a registered read port: a received frame takes up to three seen
// scans and one route scan (one seen scan for a duplicate), a local send one
// seen scan, and a tick up to one seen scan plus a sweep of both tables. No
// clearing pass is needed after reset.
module mesh_flood_relay_dedup (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [1:0]                  req_action,
   input  wire logic [31:0]                 req_now_ms,
   input  wire logic [31:0]                 req_source_id,
   input  wire logic [31:0]                 req_destination_id,
   input  wire logic [31:0]                 req_seq_num,
   input  wire logic [3:0]                  req_msg_type,
   input  wire logic [1:0]                  req_priority_req,
   input  wire logic [7:0]                  req_hop_count,
   input  wire logic [7:0]                  req_ttl_s,
   input  wire logic [31:0]                 req_sent_time_ms,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [2:0]                       rsp_kind,
   output logic [31:0]                      rsp_out_source,
   output logic [31:0]                      rsp_out_destination,
   output logic [31:0]                      rsp_out_seq,
   output logic [3:0]                       rsp_out_type,
   output logic [1:0]                       rsp_out_priority,
   output logic [7:0]                       rsp_out_hops,
   output logic [7:0]                       rsp_out_ttl,
   output logic [31:0]                      rsp_out_time,
   output logic [31:0]                      rsp_acked_seq,
   output logic [4:0]                       rsp_route_count,
   output logic                             rsp_last,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [mfr_pkg::CSR_AW-1:0]  paddr,
   input  wire logic [31:0]                 pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   mfr_pkg::cfg_type    cfg_ff, cfg_in;
   mfr_pkg::item_type   q_item;
   mfr_pkg::hand_type   hand;
   logic                q_valid, q_pop, emit_free;
   logic [2:0]          reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (reg_idx)
            mfr_pkg::REG_DEVICE_ID: cfg_in.device_id = pwdata;
            mfr_pkg::REG_MAX_HOPS:  cfg_in.max_hops  = pwdata[7:0];
            mfr_pkg::REG_HB_INT:    cfg_in.hb_int    = pwdata;
            mfr_pkg::REG_CLEAN_INT: cfg_in.clean_int = pwdata;
            mfr_pkg::REG_MAX_AGE:   cfg_in.max_age   = pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         mfr_pkg::REG_DEVICE_ID: prdata = cfg_ff.device_id;
         mfr_pkg::REG_MAX_HOPS:  prdata = 32'(cfg_ff.max_hops);
         mfr_pkg::REG_HB_INT:    prdata = cfg_ff.hb_int;
         mfr_pkg::REG_CLEAN_INT: prdata = cfg_ff.clean_int;
         mfr_pkg::REG_MAX_AGE:   prdata = cfg_ff.max_age;
         default:                prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_id <= mfr_pkg::RST_DEVICE_ID;
         cfg_ff.max_hops  <= mfr_pkg::RST_MAX_HOPS;
         cfg_ff.hb_int    <= mfr_pkg::RST_HB_INT;
         cfg_ff.clean_int <= mfr_pkg::RST_CLEAN_INT;
         cfg_ff.max_age   <= mfr_pkg::RST_MAX_AGE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mfr_front u_front (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_now_ms         (req_now_ms),
      .req_source_id      (req_source_id),
      .req_destination_id (req_destination_id),
      .req_seq_num        (req_seq_num),
      .req_msg_type       (req_msg_type),
      .req_priority_req   (req_priority_req),
      .req_hop_count      (req_hop_count),
      .req_ttl_s          (req_ttl_s),
      .req_sent_time_ms   (req_sent_time_ms),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop)
   );

   mfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .emit_free (emit_free),
      .hand      (hand)
   );

   mfr_emit u_emit (
      .clock               (clock),
      .reset               (reset),
      .hand                (hand),
      .emit_free           (emit_free),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_out_source      (rsp_out_source),
      .rsp_out_destination (rsp_out_destination),
      .rsp_out_seq         (rsp_out_seq),
      .rsp_out_type        (rsp_out_type),
      .rsp_out_priority    (rsp_out_priority),
      .rsp_out_hops        (rsp_out_hops),
      .rsp_out_ttl         (rsp_out_ttl),
      .rsp_out_time        (rsp_out_time),
      .rsp_acked_seq       (rsp_acked_seq),
      .rsp_route_count     (rsp_route_count),
      .rsp_last            (rsp_last)
   );

   a_none_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == mfr_pkg::KIND_NONE |-> rsp_last)
      else $error("empty result is not the final one of its item");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_route_count) <= 32'(mfr_pkg::ROUTE_DEPTH))
      else $error("route count above table depth");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("result burst broken before its final result");

endmodule
`default_nettype wire

// ----- verif/tb_mesh_flood_relay_dedup.sv -----
`timescale 1ns / 1ps
module tb_mesh_flood_relay_dedup;

   typedef struct {
      mfr_pkg::res_type f;
      logic [4:0]       count;
      logic             last;
   } frame_exp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = '0;
   logic [31:0] req_now_ms = '0;
   logic [31:0] req_source_id = '0;
   logic [31:0] req_destination_id = '0;
   logic [31:0] req_seq_num = '0;
   logic [3:0]  req_msg_type = '0;
   logic [1:0]  req_priority_req = '0;
   logic [7:0]  req_hop_count = '0;
   logic [7:0]  req_ttl_s = '0;
   logic [31:0] req_sent_time_ms = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [31:0] rsp_out_source, rsp_out_destination, rsp_out_seq, rsp_out_time;
   logic [31:0] rsp_acked_seq;
   logic [3:0]  rsp_out_type;
   logic [1:0]  rsp_out_priority;
   logic [7:0]  rsp_out_hops, rsp_out_ttl;
   logic [4:0]  rsp_route_count;
   logic        rsp_last;
   logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [mfr_pkg::CSR_AW-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   mesh_flood_relay_dedup uut (.*);

   always #4 clock = ~clock;

   // predictor state
   logic [31:0] dev_id, hb_int, clean_int, max_age;
   logic [7:0]  hop_limit;
   logic [31:0] seen_k[mfr_pkg::SEEN_DEPTH], seen_t[mfr_pkg::SEEN_DEPTH];
   bit          seen_v[mfr_pkg::SEEN_DEPTH];
   logic [31:0] rt_node[mfr_pkg::ROUTE_DEPTH], rt_t[mfr_pkg::ROUTE_DEPTH];
   bit          rt_v[mfr_pkg::ROUTE_DEPTH];
   logic [31:0] own_seq, last_hb, last_sweep;

   frame_exp_type frames_due[$];
   int          errors = 0;
   int          burst_left = 0;
   logic [31:0] now_t = 32'd1000;
   logic [31:0] recent_seq[$];

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
   endtask

   function automatic int seen_lookup(logic [31:0] key);
      for (int i = 0; i < mfr_pkg::SEEN_DEPTH; i++)
         if (seen_v[i] && seen_k[i] == key) return i;
      return -1;
   endfunction

   task automatic seen_note(logic [31:0] key, logic [31:0] now);
      int slot;
      logic [31:0] best, age;
      slot = seen_lookup(key);
      best = 0;
      for (int i = 0; i < mfr_pkg::SEEN_DEPTH && slot < 0; i++)
         if (!seen_v[i]) slot = i;
      if (slot < 0) begin
         slot = 0;
         for (int i = 0; i < mfr_pkg::SEEN_DEPTH; i++) begin
            age = now - seen_t[i];
            if (i == 0 || age > best) begin
               best = age;
               slot = i;
            end
         end
      end
      seen_k[slot] = key;
      seen_t[slot] = now;
      seen_v[slot] = 1'b1;
   endtask

   task automatic route_note(logic [31:0] node, logic [31:0] now);
      int slot;
      logic [31:0] best, age;
      slot = -1;
      best = 0;
      for (int i = 0; i < mfr_pkg::ROUTE_DEPTH && slot < 0; i++)
         if (rt_v[i] && rt_node[i] == node) slot = i;
      for (int i = 0; i < mfr_pkg::ROUTE_DEPTH && slot < 0; i++)
         if (!rt_v[i]) slot = i;
      if (slot < 0) begin
         slot = 0;
         for (int i = 0; i < mfr_pkg::ROUTE_DEPTH; i++) begin
            age = now - rt_t[i];
            if (i == 0 || age > best) begin
               best = age;
               slot = i;
            end
         end
      end
      rt_node[slot] = node;
      rt_t[slot] = now;
      rt_v[slot] = 1'b1;
   endtask

   task automatic claim_seq(input logic [31:0] now, output logic [31:0] s);
      s = own_seq;
      own_seq = own_seq + 1;
      seen_note(s, now);
      recent_seq.push_back(s);
   endtask

   function automatic mfr_pkg::res_type frame(logic [2:0] k, logic [31:0] src, dst, seq,
                                              logic [3:0] mt, logic [1:0] pri,
                                              logic [7:0] hops, ttl,
                                              logic [31:0] tm, acked);
      mfr_pkg::res_type f;
      f.kind = k; f.src = src; f.dst = dst; f.seq = seq; f.mtype = mt; f.pri = pri;
      f.hops = hops; f.ttl = ttl; f.tstamp = tm; f.acked = acked;
      return f;
   endfunction

   task automatic predict_frames(logic [1:0] act, logic [31:0] now, src, dst, seq,
                                 logic [3:0] mt, logic [1:0] pri, logic [7:0] hops,
                                 logic [7:0] ttl, logic [31:0] sent);
      mfr_pkg::res_type out[$];
      frame_exp_type e;
      logic [31:0] s, elapsed;
      bit for_us;
      int cnt;
      elapsed = now - sent;
      if (act == mfr_pkg::ACT_RX) begin
         if (seen_lookup(seq) < 0) begin
            for_us = (dst == dev_id || dst == mfr_pkg::BROADCAST_ID);
            seen_note(seq, now);
            route_note(src, now);
            if (for_us) begin
               out.push_back(frame(mfr_pkg::KIND_DELIVER, src, dst, seq, mt, pri, hops,
                                   ttl, sent, '0));
               if (dst != mfr_pkg::BROADCAST_ID) begin
                  claim_seq(now, s);
                  out.push_back(frame(mfr_pkg::KIND_ACK, dev_id, src, s, mfr_pkg::MSG_ACK,
                                      mfr_pkg::PRI_HIGH, '0, mfr_pkg::ACK_TTL, now, seq));
               end
            end
            if (hops < hop_limit && elapsed / mfr_pkg::MS_PER_S <= {24'd0, ttl} &&
                mt != mfr_pkg::MSG_ACK && mt != mfr_pkg::MSG_NACK && for_us) begin
               seen_note(seq, now);
               out.push_back(frame(mfr_pkg::KIND_RELAY, src, dst, seq, mt, pri,
                                   hops + 8'd1, ttl, sent, '0));
            end
         end
      end else if (act == mfr_pkg::ACT_SEND) begin
         claim_seq(now, s);
         out.push_back(frame(mfr_pkg::KIND_LOCAL, dev_id, mfr_pkg::BROADCAST_ID, s,
                             mfr_pkg::MSG_INCIDENT, pri, '0, mfr_pkg::OWN_TTL, now, '0));
      end else if (act == mfr_pkg::ACT_TICK) begin
         if (now - last_hb > hb_int) begin
            claim_seq(now, s);
            out.push_back(frame(mfr_pkg::KIND_HEARTBEAT, dev_id, mfr_pkg::BROADCAST_ID, s,
                                mfr_pkg::MSG_HEARTBEAT, mfr_pkg::PRI_LOW, '0,
                                mfr_pkg::OWN_TTL, now, '0));
            last_hb = now;
         end
         if (now - last_sweep > clean_int) begin
            for (int i = 0; i < mfr_pkg::ROUTE_DEPTH; i++)
               if (rt_v[i] && now - rt_t[i] > max_age) rt_v[i] = 1'b0;
            for (int i = 0; i < mfr_pkg::SEEN_DEPTH; i++)
               if (seen_v[i] && now - seen_t[i] > max_age) seen_v[i] = 1'b0;
            last_sweep = now;
         end
      end
      if (out.size() == 0)
         out.push_back(frame(mfr_pkg::KIND_NONE, '0, '0, '0, '0, '0, '0, '0, '0, '0));
      cnt = 0;
      for (int i = 0; i < mfr_pkg::ROUTE_DEPTH; i++) if (rt_v[i]) cnt++;
      foreach (out[i]) begin
         e.f = out[i];
         e.count = cnt[4:0];
         e.last = (i == out.size() - 1);
         frames_due.push_back(e);
      end
   endtask

   // one transfer on the request channel; called at a falling edge, returns at one
   task automatic send_item(logic [1:0] act, logic [31:0] now, src, dst, seq,
                            logic [3:0] mt, logic [1:0] pri, logic [7:0] hops,
                            logic [7:0] ttl, logic [31:0] sent);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_action <= act; req_now_ms <= now; req_source_id <= src;
      req_destination_id <= dst; req_seq_num <= seq; req_msg_type <= mt;
      req_priority_req <= pri; req_hop_count <= hops; req_ttl_s <= ttl;
      req_sent_time_ms <= sent;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_frames(act, now, src, dst, seq, mt, pri, hops, ttl, sent);
      @(negedge clock);
   endtask

   // hold off until the block has drained every frame
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (frames_due.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= mfr_pkg::CSR_AW'(idx) << 2; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         mfr_pkg::REG_DEVICE_ID: dev_id = value;
         mfr_pkg::REG_MAX_HOPS:  hop_limit = value[7:0];
         mfr_pkg::REG_HB_INT:    hb_int = value;
         mfr_pkg::REG_CLEAN_INT: clean_int = value;
         mfr_pkg::REG_MAX_AGE:   max_age = value;
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(logic [31:0] id, logic [7:0] mh, logic [31:0] hb,
                            logic [31:0] cl, logic [31:0] age);
      wait_idle();
      csr_write(mfr_pkg::REG_DEVICE_ID, id);
      csr_write(mfr_pkg::REG_MAX_HOPS, {24'd0, mh});
      csr_write(mfr_pkg::REG_HB_INT, hb);
      csr_write(mfr_pkg::REG_CLEAN_INT, cl);
      csr_write(mfr_pkg::REG_MAX_AGE, age);
   endtask

   task automatic test_received_frames();
      logic [31:0] n;
      n = now_t;
      // unicast to us: deliver, ack, relay
      send_item(mfr_pkg::ACT_RX, n, 32'h11, dev_id, 32'h100, 4'd5, 2'd1, 8'd0, 8'd10,
                n - 500);
      // duplicate of the same number
      send_item(mfr_pkg::ACT_RX, n, 32'h11, dev_id, 32'h100, 4'd5, 2'd1, 8'd0, 8'd10, n);
      // broadcast: deliver and relay, no ack
      send_item(mfr_pkg::ACT_RX, n, 32'h22, mfr_pkg::BROADCAST_ID, 32'h101,
                mfr_pkg::MSG_INCIDENT, 2'd3, 8'd2, 8'd255, n);
      // ack and nack are never relayed
      send_item(mfr_pkg::ACT_RX, n, 32'h22, mfr_pkg::BROADCAST_ID, 32'h102,
                mfr_pkg::MSG_ACK, 2'd0, 8'd0, 8'd5, n);
      send_item(mfr_pkg::ACT_RX, n, 32'h22, dev_id, 32'h103, mfr_pkg::MSG_NACK, 2'd2,
                8'd0, 8'd5, n);
      // hop count at the limit, then one just past the lifetime and one at its edge
      send_item(mfr_pkg::ACT_RX, n, 32'h33, mfr_pkg::BROADCAST_ID, 32'h104, 4'd7, 2'd1,
                8'd5, 8'd5, n);
      send_item(mfr_pkg::ACT_RX, n, 32'h33, mfr_pkg::BROADCAST_ID, 32'h105, 4'd7, 2'd1,
                8'd0, 8'd2, n - 3000);
      send_item(mfr_pkg::ACT_RX, n, 32'h33, mfr_pkg::BROADCAST_ID, 32'h106, 4'd7, 2'd1,
                8'd0, 8'd2, n - 2999);
      // addressed elsewhere: route learned, only an empty result emitted
      send_item(mfr_pkg::ACT_RX, n, 32'h44, 32'h5555, 32'h107, 4'd4, 2'd1, 8'd0, 8'd5, n);
      // field extremes
      send_item(mfr_pkg::ACT_RX, n, 32'h0, mfr_pkg::BROADCAST_ID, 32'hFFFF_FFFF, 4'd15,
                2'd3, 8'd255, 8'd255, 32'hFFFF_FFFF);
      send_item(mfr_pkg::ACT_RX, n, 32'hFFFF_FFFF, dev_id, 32'h0, mfr_pkg::MSG_HEARTBEAT,
                2'd0, 8'd0, 8'd0, n);
      // a number this node used itself is a duplicate
      send_item(mfr_pkg::ACT_RX, n, 32'h55, mfr_pkg::BROADCAST_ID, own_seq - 1, 4'd6,
                2'd1, 8'd0, 8'd9, n);
   endtask

   task automatic test_local_and_tick();
      send_item(mfr_pkg::ACT_SEND, now_t, '0, '0, '0, '0, 2'd3, '0, '0, '0);
      send_item(mfr_pkg::ACT_SEND, now_t, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                4'hF, 2'd0, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
      // first tick beats and sweeps, the next one is quiet
      now_t = now_t + 32'd400000;
      send_item(mfr_pkg::ACT_TICK, now_t, '0, '0, '0, '0, '0, '0, '0, '0);
      send_item(mfr_pkg::ACT_TICK, now_t + 1, '0, '0, '0, '0, '0, '0, '0, '0);
      send_item(mfr_pkg::ACT_UNUSED, now_t, 32'h66, dev_id, 32'h200, 4'd5, 2'd1, 8'd0,
                8'd9, now_t);
   endtask

   task automatic random_item(int step_max);
      logic [1:0]  act;
      logic [31:0] src, dst, seq, sent;
      logic [7:0]  hops, ttl;
      int pick;
      pick = $urandom_range(0, 99);
      act = (pick < 60) ? mfr_pkg::ACT_RX : (pick < 75) ? mfr_pkg::ACT_SEND :
            (pick < 95) ? mfr_pkg::ACT_TICK : mfr_pkg::ACT_UNUSED;
      if ($urandom_range(0, 19) == 0) now_t = $urandom;
      else now_t = now_t + $urandom_range(0, step_max);
      src = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 24);
      pick = $urandom_range(0, 9);
      dst = (pick < 4) ? dev_id : (pick < 8) ? mfr_pkg::BROADCAST_ID : $urandom;
      pick = $urandom_range(0, 9);
      if (pick < 3 && recent_seq.size() > 0)
         seq = recent_seq[$urandom_range(0, recent_seq.size() - 1)];
      else if (pick < 5) seq = $urandom;
      else seq = $urandom_range(0, 4000);
      if (act == mfr_pkg::ACT_RX) recent_seq.push_back(seq);
      if (recent_seq.size() > 40) void'(recent_seq.pop_front());
      hops = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
      ttl = 8'($urandom);
      sent = ($urandom_range(0, 5) == 0) ? $urandom
             : now_t - $urandom_range(0, 1000 * ttl + 2000);
      send_item(act, now_t, src, dst, seq, 4'($urandom), 2'($urandom), hops, ttl, sent);
   endtask

   task automatic test_random(int items, int step_max);
      repeat (items) random_item(step_max);
   endtask

   // receiver stall pattern: free-running, random, or periodic blocks
   int ready_cyc = 0;
   int ready_mode = 0;
   always @(negedge clock) begin
      ready_cyc <= ready_cyc + 1;
      if (ready_cyc % 97 == 0) ready_mode <= $urandom_range(0, 2);
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ((ready_cyc % 16) < 4);
      endcase
   end

   always @(posedge clock) begin
      frame_exp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frames_due.size() == 0) begin
            report("unexpected transfer kind", 32'(rsp_kind), 32'd0);
         end else begin
            e = frames_due.pop_front();
            if (rsp_kind != e.f.kind) report("kind", 32'(rsp_kind), 32'(e.f.kind));
            if (rsp_out_source != e.f.src) report("out_source", rsp_out_source, e.f.src);
            if (rsp_out_destination != e.f.dst)
               report("out_destination", rsp_out_destination, e.f.dst);
            if (rsp_out_seq != e.f.seq) report("out_seq", rsp_out_seq, e.f.seq);
            if (rsp_out_type != e.f.mtype)
               report("out_type", 32'(rsp_out_type), 32'(e.f.mtype));
            if (rsp_out_priority != e.f.pri)
               report("out_priority", 32'(rsp_out_priority), 32'(e.f.pri));
            if (rsp_out_hops != e.f.hops)
               report("out_hops", 32'(rsp_out_hops), 32'(e.f.hops));
            if (rsp_out_ttl != e.f.ttl) report("out_ttl", 32'(rsp_out_ttl), 32'(e.f.ttl));
            if (rsp_out_time != e.f.tstamp) report("out_time", rsp_out_time, e.f.tstamp);
            if (rsp_acked_seq != e.f.acked) report("acked_seq", rsp_acked_seq, e.f.acked);
            if (rsp_route_count != e.count)
               report("route_count", 32'(rsp_route_count), 32'(e.count));
            if (rsp_last !== e.last) report("last", 32'(rsp_last), 32'(e.last));
         end
      end
   end

   initial begin
      dev_id = mfr_pkg::RST_DEVICE_ID; hop_limit = mfr_pkg::RST_MAX_HOPS;
      hb_int = mfr_pkg::RST_HB_INT; clean_int = mfr_pkg::RST_CLEAN_INT;
      max_age = mfr_pkg::RST_MAX_AGE;
      foreach (seen_v[i]) seen_v[i] = 1'b0;
      foreach (rt_v[i]) rt_v[i] = 1'b0;
      own_seq = 32'd1; last_hb = 0; last_sweep = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // reset values first, then a node identity
      test_random(10, 20000);
      configure(32'h1234_5678, 8'd5, 32'd30000, 32'd60000, 32'd300000);
      test_received_frames();
      test_local_and_tick();
      configure($urandom, 8'd3, 32'd500, 32'd1000, 32'd4000);
      test_random(60, 1500);
      configure(32'hFFFF_FFFF, 8'd255, 32'd1, 32'd1, 32'd1);
      test_random(40, 3);
      configure(32'd0, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      test_random(40, 50000);
      wait_idle();
      repeat (200) @(posedge clock);
      if (errors == 0) $display("[mesh_flood_relay_dedup] OK");
      else $display("[mesh_flood_relay_dedup] ERROR");
      $finish;
   end

   initial begin
      #20ms;
      $display("[mesh_flood_relay_dedup] ERROR");
      $finish;
   end
endmodule
